/* hdl/lsra_pkg.sv */
// Shared constants for the linear scan register allocator.
package lsra_pkg;

  // Width of the registers-in-use configuration register.
  localparam int unsigned CFG_W = 5;

  // Width of the real register number on the result channel.
  localparam int unsigned ASSIGNED_REG_W = 4;

  // Reset value of the registers-in-use register.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage : lsra_pkg

/* hdl/linear_scan_register_allocator_top.sv */
// Linear scan register allocator: slot table, scan sequencer and result register.
//
// Usage:
//   Input channel (in_valid / in_stall): one live interval per request, given in
//   ascending virtual register order. Set in_new_function on the first interval
//   of a function to free every slot before that interval is handled.
//   Result channel (out_valid / out_stall): one result per request, carrying the
//   virtual register echo, the real register given or a memory placement, and
//   the earlier virtual register spilled to make room, if any.
//   Configuration: cfg_wr_en / cfg_wr_data write the number of real registers in
//   use; values above MAX_REAL_REGS act as MAX_REAL_REGS. Write only while idle.
// Operation:
//   Each request is accepted, then scanned one slot per cycle through the shared
//   expiry / free / longest-range compare unit over the N registers in use (the
//   scan is skipped when N is zero), then committed to its slot and the result
//   register. in_stall is high from acceptance until the request commits.
// Reset (rst_n, synchronous, active low): every slot free, register count 16,
// result register empty. When the receiver stalls, the result holds; a new
// request is still accepted and scanned, and its commit waits for the result
// register to drain.
module linear_scan_register_allocator_top #(
  parameter int unsigned MAX_REAL_REGS = 16,
  parameter int unsigned VREG_BITS     = 10,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [lsra_pkg::CFG_W-1:0]          cfg_wr_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_new_function,
  input  logic [VREG_BITS-1:0]                in_virtual_reg,
  input  logic [POSITION_BITS-1:0]            in_def_position,
  input  logic [POSITION_BITS-1:0]            in_last_use_position,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [VREG_BITS-1:0]                out_this_vreg,
  output logic                                out_in_memory,
  output logic [lsra_pkg::ASSIGNED_REG_W-1:0] out_assigned_reg,
  output logic                                out_victim_valid,
  output logic [VREG_BITS-1:0]                out_victim_vreg
);

  import lsra_pkg::*;

  // Slot index and register count widths.
  localparam int unsigned SLOT_W = (MAX_REAL_REGS > 1) ? $clog2(MAX_REAL_REGS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_REAL_REGS + 1);
  localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned OREG_W = (SLOT_W > ASSIGNED_REG_W) ? SLOT_W : ASSIGNED_REG_W;
  // Signed range length needs one more bit than a position.
  localparam int unsigned LEN_W  = POSITION_BITS + 1;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_REAL_REGS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic [CFG_W-1:0]            regs_in_use_r;
  logic [MAX_REAL_REGS-1:0]    busy_r;
  logic [CNT_W-1:0]            count_r;
  logic [SLOT_W-1:0]           idx_r;

  // request being handled
  logic [VREG_BITS-1:0]        vreg_r;
  logic [POSITION_BITS-1:0]    def_r;
  logic [POSITION_BITS-1:0]    last_r;
  logic signed [LEN_W-1:0]     len_r;

  // scan results
  logic                        free_found_r;
  logic [SLOT_W-1:0]           free_slot_r;
  logic                        victim_found_r;
  logic [SLOT_W-1:0]           best_slot_r;
  logic signed [LEN_W-1:0]     best_len_r;
  logic [VREG_BITS-1:0]        best_owner_r;

  // result register
  logic                        out_valid_r;
  logic [VREG_BITS-1:0]        out_vreg_r;
  logic                        out_mem_r;
  logic [ASSIGNED_REG_W-1:0]   out_reg_r;
  logic                        out_victim_r;
  logic [VREG_BITS-1:0]        out_victim_vreg_r;

  // slot table: owner, last use and precomputed range length of each occupant
  logic [VREG_BITS-1:0]        slot_owner [MAX_REAL_REGS];
  logic [POSITION_BITS-1:0]    slot_last  [MAX_REAL_REGS];
  logic signed [LEN_W-1:0]     slot_len   [MAX_REAL_REGS];

  logic                        in_accept;
  logic                        out_free;
  logic [CMP_W-1:0]            cfg_ext;
  logic [CNT_W-1:0]            count_eff;
  logic signed [LEN_W-1:0]     in_len;
  logic                        scan_busy;
  logic                        scan_expire;
  logic                        scan_free;
  logic                        scan_longer;
  logic                        scan_last;
  logic                        placed;
  logic [SLOT_W-1:0]           place_slot;
  logic [OREG_W-1:0]           place_slot_ext;
  logic                        commit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Saturate the register count to the slot table depth.
  assign cfg_ext   = CMP_W'(regs_in_use_r);
  assign count_eff = (cfg_ext > MAX_CMP) ? CNT_W'(MAX_REAL_REGS) : CNT_W'(regs_in_use_r);

  assign in_len = $signed({1'b0, in_last_use_position}) - $signed({1'b0, in_def_position});

  // Shared per-slot unit: expiry compare and longest-range compare.
  assign scan_busy   = busy_r[idx_r];
  assign scan_expire = scan_busy && (slot_last[idx_r] <= def_r);
  assign scan_free   = !scan_busy || scan_expire;
  assign scan_longer = !scan_free && (slot_len[idx_r] > best_len_r);
  assign scan_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // Take the lowest free slot, else the longest occupant if it beat the new range.
  assign placed         = free_found_r || victim_found_r;
  assign place_slot     = free_found_r ? free_slot_r : best_slot_r;
  assign place_slot_ext = OREG_W'(place_slot);
  assign commit         = (state_r == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      regs_in_use_r <= CFG_RESET;
      busy_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        regs_in_use_r <= cfg_wr_data;
      end
      // Drop the result once taken, unless a new one loads in the same cycle.
      if (out_valid_r && !out_stall && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            vreg_r         <= in_virtual_reg;
            def_r          <= in_def_position;
            last_r         <= in_last_use_position;
            len_r          <= in_len;
            best_len_r     <= in_len;
            count_r        <= count_eff;
            idx_r          <= '0;
            free_found_r   <= 1'b0;
            victim_found_r <= 1'b0;
            if (in_new_function) begin
              busy_r <= '0;
            end
            // No usable slot: skip the scan and go to memory.
            state_r <= (count_eff == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_expire) begin
            busy_r[idx_r] <= 1'b0;
          end
          if (scan_free && !free_found_r) begin
            free_found_r <= 1'b1;
            free_slot_r  <= idx_r;
          end
          if (scan_longer) begin
            victim_found_r <= 1'b1;
            best_slot_r    <= idx_r;
            best_len_r     <= slot_len[idx_r];
            best_owner_r   <= slot_owner[idx_r];
          end
          if (scan_last) begin
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + SLOT_W'(1);
          end
        end
        S_DONE: begin
          // Hold until the result register can take the result.
          if (commit) begin
            if (placed) begin
              busy_r[place_slot] <= 1'b1;
            end
            out_valid_r       <= 1'b1;
            out_vreg_r        <= vreg_r;
            out_mem_r         <= !placed;
            out_reg_r         <= placed ? place_slot_ext[ASSIGNED_REG_W-1:0] : '0;
            out_victim_r      <= !free_found_r && victim_found_r;
            out_victim_vreg_r <= (!free_found_r && victim_found_r) ? best_owner_r : '0;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Slot table write on commit.
  always_ff @(posedge clk) begin
    if (commit && placed) begin
      slot_owner[place_slot] <= vreg_r;
      slot_last[place_slot]  <= last_r;
      slot_len[place_slot]   <= len_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_this_vreg    = out_vreg_r;
  assign out_in_memory    = out_mem_r;
  assign out_assigned_reg = out_reg_r;
  assign out_victim_valid = out_victim_r;
  assign out_victim_vreg  = out_victim_vreg_r;

endmodule : linear_scan_register_allocator_top
